>>> hw/rtl/nls_pkg.sv
package nls_pkg;

  // Fixed port widths.
  localparam int XW    = 32;
  localparam int LOG_W = 32;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] SERIES_TERMS_RESET = 5'd20;

  // ln 2 as unsigned Q0.64.
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> hw/rtl/nls_in_if.sv
interface nls_in_if;
  logic                   valid;
  logic                   ready;
  logic [nls_pkg::XW-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

>>> hw/rtl/nls_out_if.sv
interface nls_out_if;
  logic                      valid;
  logic                      ready;
  logic [nls_pkg::LOG_W-1:0] log_value;
  logic                      input_invalid;

  modport source (output valid, output log_value, output input_invalid, input ready);
  modport sink (input valid, input log_value, input input_invalid, output ready);
endinterface

>>> hw/rtl/nls_div.sv
// Restoring divider, one quotient bit per cycle. The initial remainder must be
// below the divisor, so the quotient of (rem_init * 2^W + dividend) / divisor
// fits in W bits.
module nls_div #(
  parameter int W = 27
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W+1:0]      rem_init,
  input  logic [W-1:0]      dividend,
  input  logic [W+1:0]      divisor,
  output nls_pkg::div_sts_t sts,
  output logic [W-1:0]      quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W+1:0]  rem_r;
  logic [W-1:0]  dvd_r;
  logic [W+1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W+2:0]  trial;
  logic          ge;
  logic [W+2:0]  diff;

  assign trial = {rem_r, dvd_r[W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W+1:0] : trial[W+1:0];
      dvd_r <= {dvd_r[W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule

>>> hw/rtl/nls_mul.sv
// Unsigned W x W multiplier with a registered product.
module nls_mul #(
  parameter int W = 27
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] prod
);

  logic [2*W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

>>> hw/rtl/natural_log_series.sv
// Channel   Dir  Payload                                  Handshake
// in_chan   in   x_value (Q16.16, unsigned)               valid / ready
// out_chan  out  log_value (Q4.27, signed), input_invalid valid / ready
// cfg       in   cfg_wr_data = series_terms               cfg_wr_en, no stall
//
// The bit-serial divider forms t and every term, so W, the output fraction
// bits, and the number of series terms run (at most series_terms) set the time
// from acceptance to a valid result. A zero operand goes straight to the
// result. The next transaction is taken in the idle cycle that follows. Reset
// is synchronous and clears control only.
// in_chan is ready only when the sequencer is idle; the output register lets a
// new transaction start while the previous result waits on out_chan.
module natural_log_series #(
  parameter int INPUT_FRACTION_BITS  = 16,
  parameter int OUTPUT_FRACTION_BITS = 27,
  parameter int MAX_SERIES_TERMS     = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [nls_pkg::CFG_W-1:0]   cfg_wr_data,
  nls_in_if.sink                      in_chan,
  nls_out_if.source                   out_chan
);

  localparam int W  = OUTPUT_FRACTION_BITS;
  localparam int KW = $clog2(MAX_SERIES_TERMS + 1);
  localparam int RW = (W + 8 > 33) ? W + 8 : 33;

  localparam logic [W-1:0] LN2Q = W'(nls_pkg::LN2_Q64 >> (64 - W));
  localparam logic signed [RW-1:0] SAT_HI = RW'(signed'(32'h7FFF_FFFF));
  localparam logic signed [RW-1:0] SAT_LO = RW'(signed'(32'h8000_0000));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_FDIV = 4'd2;
  localparam logic [3:0] S_TDIV = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQW  = 4'd5;
  localparam logic [3:0] S_TM   = 4'd6;
  localparam logic [3:0] S_TMW  = 4'd7;
  localparam logic [3:0] S_NDIV = 4'd8;
  localparam logic [3:0] S_LNM  = 4'd9;
  localparam logic [3:0] S_LNW  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]                  state_r, state_nxt;
  logic [nls_pkg::CFG_W-1:0]   series_terms_r;
  logic [nls_pkg::XW-1:0]      v_r;
  logic [4:0]                  lz_r;
  logic [2:0]                  step_r;
  logic signed [6:0]           m_r;
  logic [W-1:0]                t_r;
  logic [W-1:0]                tsq_r;
  logic [W-1:0]                term_r;
  logic [W:0]                  sum_r;
  logic [KW-1:0]               k_r;
  logic [nls_pkg::LOG_W-1:0]   res_log_r;
  logic                        res_inv_r;
  logic [nls_pkg::LOG_W-1:0]   out_log_r;
  logic                        out_inv_r;
  logic                        out_valid_r;

  logic                        in_acc;
  logic                        out_load;
  logic [5:0]                  amt;
  logic                        hi_zero;
  logic [KW-1:0]               lim;
  logic [W-1:0]                f_w;
  logic [6:0]                  m_abs;
  logic [W-1:0]                mul_a, mul_b;
  logic [2*W-1:0]              mul_prod;
  logic [W-1:0]                prod_hi;
  logic                        div_start;
  logic [W+1:0]                div_rem, div_dsr;
  logic [W-1:0]                div_dvd, div_q;
  nls_pkg::div_sts_t           div_sts;
  logic                        last_term;
  logic [RW-1:0]               sum2, lnp;
  logic signed [RW-1:0]        res;
  logic [nls_pkg::LOG_W-1:0]   res_sat;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  // Binary search for the leading one: shifts of 16, 8, 4, 2, 1.
  assign amt     = 6'd1 << step_r;
  assign hi_zero = (v_r >> (6'd32 - amt)) == '0;
  assign f_w     = v_r[30 -: W];

  assign lim = ({1'b0, series_terms_r} > 6'(MAX_SERIES_TERMS)) ?
               KW'(MAX_SERIES_TERMS) : KW'(series_terms_r);

  assign m_abs   = m_r[6] ? 7'(-m_r) : 7'(m_r);
  assign prod_hi = mul_prod[2*W-1:W];

  always_comb begin
    case (state_r)
      S_TM: begin
        mul_a = term_r;
        mul_b = tsq_r;
      end
      S_LNM: begin
        mul_a = W'(m_abs);
        mul_b = LN2Q;
      end
      default: begin
        mul_a = t_r;
        mul_b = t_r;
      end
    endcase
  end

  // t = (f << W) / (2^(W+1) + f) starts from remainder f; the terms from zero.
  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_dvd   = prod_hi;
    div_dsr   = (W+2)'({k_r, 1'b1});
    if (state_r == S_FDIV) begin
      div_start = !div_sts.busy;
      div_rem   = {2'b00, f_w};
      div_dvd   = '0;
      div_dsr   = {2'b10, f_w};
    end else if (state_r == S_TMW) begin
      div_start = !div_sts.busy;
    end
  end

  assign last_term = (div_q == '0) || (k_r == lim);

  assign sum2 = RW'({sum_r, 1'b0});
  assign lnp  = RW'(mul_prod[W+5:0]);
  assign res  = m_r[6] ? signed'(sum2 - lnp) : signed'(sum2 + lnp);

  always_comb begin
    if (res > SAT_HI) begin
      res_sat = SAT_HI[nls_pkg::LOG_W-1:0];
    end else if (res < SAT_LO) begin
      res_sat = SAT_LO[nls_pkg::LOG_W-1:0];
    end else begin
      res_sat = res[nls_pkg::LOG_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.x_value == '0) ? S_FIN : S_NORM;
        end
      end
      S_NORM: begin
        if (step_r == 3'd0) begin
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: state_nxt = S_TDIV;
      S_TDIV: begin
        if (div_sts.done) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ:   state_nxt = S_SQW;
      S_SQW:  state_nxt = (lim == '0) ? S_LNM : S_TM;
      S_TM:   state_nxt = S_TMW;
      S_TMW:  state_nxt = S_NDIV;
      S_NDIV: begin
        if (div_sts.done) begin
          state_nxt = last_term ? S_LNM : S_TM;
        end
      end
      S_LNM:  state_nxt = S_LNW;
      S_LNW:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      series_terms_r <= nls_pkg::SERIES_TERMS_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        series_terms_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        v_r       <= in_chan.x_value;
        lz_r      <= '0;
        step_r    <= 3'd4;
        res_log_r <= '0;
        res_inv_r <= 1'b1;
      end
      S_NORM: begin
        if (hi_zero) begin
          v_r  <= v_r << amt;
          lz_r <= lz_r + amt[4:0];
        end
        step_r <= step_r - 3'd1;
      end
      S_FDIV: begin
        m_r <= signed'(7'(5'd31 - lz_r)) - 7'(INPUT_FRACTION_BITS);
      end
      S_TDIV: begin
        t_r <= div_q;
      end
      S_SQW: begin
        tsq_r  <= prod_hi;
        term_r <= t_r;
        sum_r  <= {1'b0, t_r};
        k_r    <= KW'(1);
      end
      S_TMW: begin
        term_r <= prod_hi;
      end
      S_NDIV: begin
        if (div_sts.done) begin
          sum_r <= sum_r + (W+1)'(div_q);
          k_r   <= k_r + KW'(1);
        end
      end
      S_LNW: begin
        res_log_r <= res_sat;
        res_inv_r <= 1'b0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_log_r <= res_log_r;
      out_inv_r <= res_inv_r;
    end
  end

  nls_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_q)
  );

  nls_mul #(.W(W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.log_value     = out_log_r;
  assign out_chan.input_invalid = out_inv_r;

endmodule

>>> hw/rtl/nls_chk.sv
module nls_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [nls_pkg::LOG_W-1:0] log_value,
  input logic                      input_invalid
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_chan valid dropped while stalled");

  // The sequencer leaves idle as soon as it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_chan still ready right after a transaction");

  // A zero operand always reports a zero logarithm.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && input_invalid |-> log_value == '0)
    else $error("invalid result with nonzero log_value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_chan valid after reset");

endmodule

bind natural_log_series nls_chk u_nls_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .log_value     (out_chan.log_value),
  .input_invalid (out_chan.input_invalid)
);
